// File: rtl/core/frgcd_pkg.sv
// Shared types, widths and helpers for the fraction reducer.
package frgcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EU_START,
        ST_EU_RUN,
        ST_QN_START,
        ST_QN_RUN,
        ST_QD_START,
        ST_QD_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_EUCLID,
        SEL_NUM,
        SEL_DEN
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     euclid_step;
        logic     take_b_as_g;
        logic     take_den_as_g;
        logic     save_qnum;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic num_zero;
        logic den_zero;
    } dp_status_t;

    // Magnitude of a two's complement word; the most negative value maps to 2^(W-1).
    function automatic data_t mag(input data_t v);
        mag = v[DATA_WIDTH-1] ? (~v + data_t'(1)) : v;
    endfunction

    function automatic data_t apply_sign(input data_t m, input logic neg);
        apply_sign = neg ? (~m + data_t'(1)) : m;
    endfunction

endpackage

// File: rtl/core/fraction_reduce_gcd_top.sv
// Fraction reducer top level: signed numerator and denominator in, reduced pair out.
// Each transfer in is reduced by the divisor found with the truncating-remainder Euclid
// loop seeded with (denominator, numerator), then both values are divided by it; one
// result transfer follows each input transfer. One item is worked on at a time, and all
// of its divisions go through a single radix-2 divider. A zero numerator skips the loop,
// and a zero denominator passes the inputs through with zero_denominator_error set.
// A new input is taken while a finished result waits in the output register.
module fraction_reduce_gcd_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  frgcd_pkg::data_t    numerator,
    input  frgcd_pkg::data_t    denominator,
    output logic                out_valid,
    input  logic                out_stall,
    output frgcd_pkg::data_t    reduced_numerator,
    output frgcd_pkg::data_t    reduced_denominator,
    output logic                zero_denominator_error
);
    import frgcd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    frgcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    frgcd_dp u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .status                 (status),
        .numerator              (numerator),
        .denominator            (denominator),
        .reduced_numerator      (reduced_numerator),
        .reduced_denominator    (reduced_denominator),
        .zero_denominator_error (zero_denominator_error)
    );

endmodule

// File: rtl/core/frgcd_div.sv
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
module frgcd_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  frgcd_pkg::data_t     dividend,
    input  frgcd_pkg::data_t     divisor,
    output logic                 done,
    output frgcd_pkg::data_t     quotient,
    output frgcd_pkg::data_t     remainder
);
    import frgcd_pkg::*;

    data_t                 rem_reg;
    data_t                 quo_reg;
    data_t                 dsr_reg;
    cnt_t                  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    // The partial remainder stays below twice the divisor, so the top bit is the borrow.
    assign fits    = ~diff[DATA_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cnt_t'(DATA_WIDTH - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - cnt_t'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/frgcd_dp.sv
// Datapath: operand and divisor registers, Euclid update, sign handling, result register.
module frgcd_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  frgcd_pkg::ctrl_cmd_t   cmd,
    output frgcd_pkg::dp_status_t  status,
    input  frgcd_pkg::data_t       numerator,
    input  frgcd_pkg::data_t       denominator,
    output frgcd_pkg::data_t       reduced_numerator,
    output frgcd_pkg::data_t       reduced_denominator,
    output logic                   zero_denominator_error
);
    import frgcd_pkg::*;

    data_t num_reg;
    data_t den_reg;
    data_t ma_reg;
    data_t mb_reg;
    data_t g_reg;
    data_t qnum_reg;
    logic  parity_reg;
    logic  gneg_reg;
    data_t rnum_reg;
    data_t rden_reg;
    logic  err_reg;

    data_t div_dividend;
    data_t div_divisor;
    logic  div_done;
    data_t div_quo;
    data_t div_rem;
    logic  num_neg;
    logic  den_neg;

    assign num_neg = num_reg[DATA_WIDTH-1];
    assign den_neg = den_reg[DATA_WIDTH-1];

    always_comb
    begin
        case (cmd.div_sel)
            SEL_EUCLID:
            begin
                div_dividend = ma_reg;
                div_divisor  = mb_reg;
            end
            SEL_NUM:
            begin
                div_dividend = mag(num_reg);
                div_divisor  = g_reg;
            end
            SEL_DEN:
            begin
                div_dividend = mag(den_reg);
                div_divisor  = g_reg;
            end
            default:
            begin
                div_dividend = ma_reg;
                div_divisor  = mb_reg;
            end
        endcase
    end

    frgcd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Remainder signs follow the dividend, so the divisor's sign alternates
    // between the numerator's and the denominator's with each Euclid step.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg    <= numerator;
            den_reg    <= denominator;
            ma_reg     <= mag(denominator);
            mb_reg     <= mag(numerator);
            parity_reg <= 1'b0;
        end
        else if (cmd.euclid_step)
        begin
            ma_reg     <= mb_reg;
            mb_reg     <= div_rem;
            parity_reg <= ~parity_reg;
        end

        if (cmd.take_b_as_g)
        begin
            g_reg    <= mb_reg;
            gneg_reg <= parity_reg ? den_neg : num_neg;
        end
        else if (cmd.take_den_as_g)
        begin
            g_reg    <= ma_reg;
            gneg_reg <= den_neg;
        end

        if (cmd.save_qnum)
        begin
            qnum_reg <= div_quo;
        end

        // The divider is idle after the denominator division, so its quotient still holds.
        if (cmd.out_load)
        begin
            if (den_reg == '0)
            begin
                rnum_reg <= num_reg;
                rden_reg <= den_reg;
                err_reg  <= 1'b1;
            end
            else
            begin
                rnum_reg <= apply_sign(qnum_reg, num_neg ^ gneg_reg);
                rden_reg <= apply_sign(div_quo, den_neg ^ gneg_reg);
                err_reg  <= 1'b0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.rem_zero = (div_rem == '0);
    assign status.num_zero = (num_reg == '0);
    assign status.den_zero = (den_reg == '0);

    assign reduced_numerator      = rnum_reg;
    assign reduced_denominator    = rden_reg;
    assign zero_denominator_error = err_reg;

endmodule

// File: rtl/core/frgcd_ctrl.sv
// Controller: sequences the Euclid loop and the two final divisions, owns both handshakes.
module frgcd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  frgcd_pkg::dp_status_t  status,
    output frgcd_pkg::ctrl_cmd_t   cmd
);
    import frgcd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        cmd.div_sel    = SEL_EUCLID;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.den_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (status.num_zero)
                begin
                    cmd.take_den_as_g = 1'b1;
                    state_next        = ST_QN_START;
                end
                else
                begin
                    state_next = ST_EU_START;
                end
            end
            ST_EU_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_EUCLID;
                state_next    = ST_EU_RUN;
            end
            ST_EU_RUN:
            begin
                cmd.div_sel = SEL_EUCLID;
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.take_b_as_g = 1'b1;
                        state_next      = ST_QN_START;
                    end
                    else
                    begin
                        cmd.euclid_step = 1'b1;
                        state_next      = ST_EU_START;
                    end
                end
            end
            ST_QN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_NUM;
                state_next    = ST_QN_RUN;
            end
            ST_QN_RUN:
            begin
                cmd.div_sel = SEL_NUM;
                if (status.div_done)
                begin
                    cmd.save_qnum = 1'b1;
                    state_next    = ST_QD_START;
                end
            end
            ST_QD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_DEN;
                state_next    = ST_QD_RUN;
            end
            ST_QD_RUN:
            begin
                cmd.div_sel = SEL_DEN;
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The result register is free once its previous transfer has gone out.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> state_reg == ST_DONE)
        else $error("finished result overwrote a pending transfer");

    a_div_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_EU_RUN || state_reg == ST_QN_RUN ||
                             state_reg == ST_QD_RUN))
        else $error("divider finished outside a run state");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg == ST_CHECK)
        else $error("accepted input did not start processing");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded without raising out_valid");
`endif

endmodule
